@@ hdl/gaps_pkg.sv @@
// ----------------------------------------------------------------------------
// gaps_pkg - grid path search shared definitions
// Grid geometry, request/response payloads, heap entry layout, sequencer
// states and the small helper functions shared by the search unit.
// ----------------------------------------------------------------------------
package gaps_pkg;

    // grid geometry (column count is a power of two: cell = {row, col})
    localparam int GRID_W         = 64;
    localparam int GRID_H         = 32;
    localparam int CELL_PX        = 30;
    localparam int OPEN_DEPTH_DEF = 8192;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 5;
    localparam int CELL_W = COL_W + ROW_W;
    localparam int NCELLS = GRID_W * GRID_H;
    localparam int IDX_W  = 11;
    localparam int LEN_W  = 12;
    localparam int FW     = 12;                        // f and g cost width
    localparam int SEQ_W  = $clog2(4 * NCELLS + 2);    // push sequence number
    localparam int PX_W   = 12;
    localparam int QW     = PX_W + 1;                  // pixel edge / quotient width

    // floor(v / CELL_PX) = (v * DIV_M) >> DIV_S, exact for every v below 2**QW
    localparam int DIV_S  = 18;
    localparam int DIV_M  = (2**DIV_S + CELL_PX - 1) / CELL_PX;

    typedef enum logic [1:0] {
        OP_CLEAR  = 2'd0,
        OP_WALL   = 2'd1,
        OP_SEARCH = 2'd2,
        OP_READ   = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOPATH = 2'd1,
        ST_RANGE  = 2'd2
    } t_status;

    // step directions: east, south, west, north
    typedef enum logic [1:0] {
        DIR_E = 2'd0,
        DIR_S = 2'd1,
        DIR_W = 2'd2,
        DIR_N = 2'd3
    } t_dir;

    typedef struct packed {
        t_op               opcode;
        logic [PX_W-1:0]   wall_center_x;
        logic [PX_W-1:0]   wall_center_y;
        logic [PX_W-1:0]   wall_width;
        logic [PX_W-1:0]   wall_height;
        logic [COL_W-1:0]  start_col;
        logic [ROW_W-1:0]  start_row;
        logic [COL_W-1:0]  goal_col;
        logic [ROW_W-1:0]  goal_row;
        logic [IDX_W-1:0]  step_index;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [LEN_W-1:0]  path_length;
        logic [COL_W-1:0]  cell_col;
        logic [ROW_W-1:0]  cell_row;
        logic              is_last_step;
    } t_rsp;

    typedef struct packed {
        logic [FW-1:0]     f;
        logic [SEQ_W-1:0]  seq;
        logic [CELL_W-1:0] loc;
        t_dir              dir;
    } t_heap_ent;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_WCLR, S_DIV, S_FILL,
        S_SGOAL, S_SCHK, S_CCLR,
        S_PUSH, S_SU_A, S_SU_B,
        S_POP0, S_POP1, S_POP2, S_SD_A, S_SD_B, S_SD_C,
        S_CLOSE0, S_CLOSE1, S_NB0, S_NB1,
        S_TR_A, S_TR_B, S_TW_A, S_TW_B,
        S_RD0, S_RD1, S_DONE
    } t_state;

    // a leaves the heap before b: lower f, then later push
    function automatic logic heap_before(input t_heap_ent a, input t_heap_ent b);
        heap_before = (a.f < b.f) || ((a.f == b.f) && (a.seq > b.seq));
    endfunction

    // Manhattan distance from a cell to the goal
    function automatic logic [FW-1:0] manhattan(input logic [CELL_W-1:0] c,
                                                input logic [COL_W-1:0] gc,
                                                input logic [ROW_W-1:0] gr);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] dc;
        logic [ROW_W-1:0] dr;
        col = c[COL_W-1:0];
        row = c[CELL_W-1:COL_W];
        dc  = (col > gc) ? col - gc : gc - col;
        dr  = (row > gr) ? row - gr : gr - row;
        manhattan = FW'(dc) + FW'(dr);
    endfunction

    // cell that a step in direction d came from
    function automatic logic [CELL_W-1:0] step_back(input logic [CELL_W-1:0] c,
                                                    input t_dir d);
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        col = c[COL_W-1:0];
        row = c[CELL_W-1:COL_W];
        case (d)
            DIR_E:   col = col - 1'b1;
            DIR_S:   row = row - 1'b1;
            DIR_W:   col = col + 1'b1;
            DIR_N:   row = row + 1'b1;
            default: col = col;
        endcase
        step_back = {row, col};
    endfunction

endpackage

@@ hdl/gaps_chan_if.sv @@
// ----------------------------------------------------------------------------
// gaps_chan_if - valid/ready request channel
// Carries one payload of type T from a source to a sink.
// ----------------------------------------------------------------------------
interface gaps_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/grid_astar_path_search_unit.sv @@
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit - 4-connected A* path search over a wall map
// Wall bitmap, rectangle rasterizer, binary-heap A* search and path store,
// all run by one sequencer over single-port-per-side memories.
//
//  channel  | dir | payload | meaning
//  ---------+-----+---------+----------------------------------------------
//  i_req    | in  | t_req   | clear / add wall / search / read path step
//  o_rsp    | out | t_rsp   | status, path length and cell read
//
// A search first clears the closed map, then pops the heap with a sift-down
// and pushes each open neighbor with a sift-up; on reaching the goal it traces
// the path back and stores it. After reset a pass clears the wall map before
// the first request. One request at a time; a finished response waits in the
// output register.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit #(
    parameter int OPEN_DEPTH = gaps_pkg::OPEN_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    gaps_chan_if.sink   i_req,
    gaps_chan_if.source o_rsp
);
    import gaps_pkg::*;

    localparam int HIW  = $clog2(OPEN_DEPTH);
    localparam int CNTW = $clog2(OPEN_DEPTH + 1);
    localparam int LW   = HIW + 2;
    localparam int PW   = QW + DIV_S;

    t_state r_state, n_state;
    t_req   r_req;

    // memories
    logic                r_wall_mem   [NCELLS];
    logic                r_closed_mem [NCELLS];
    t_dir                r_par_mem    [NCELLS];
    logic [CELL_W-1:0]   r_path_mem   [NCELLS];
    t_heap_ent           r_heap_mem   [OPEN_DEPTH];

    logic                w_wall_we, w_wall_wd, r_wall_q;
    logic [CELL_W-1:0]   w_wall_waddr, w_wall_raddr;
    logic                w_closed_we, w_closed_wd, r_closed_q;
    logic [CELL_W-1:0]   w_closed_waddr, w_closed_raddr;
    logic                w_par_we;
    t_dir                r_par_q;
    logic [CELL_W-1:0]   w_par_raddr;
    logic                w_path_we;
    logic [IDX_W-1:0]    w_path_waddr, w_path_raddr;
    logic [CELL_W-1:0]   r_path_q;
    logic                w_heap_we;
    logic [HIW-1:0]      w_heap_waddr, w_heap_raddr;
    t_heap_ent           w_heap_wd, r_heap_q;

    // sequencer registers
    logic [CELL_W-1:0]   r_sweep;
    logic [CNTW-1:0]     r_cnt;
    logic [SEQ_W-1:0]    r_seq;
    t_heap_ent           r_cur, r_mov, r_cl;
    logic [FW-1:0]       r_cur_g;
    logic [HIW-1:0]      r_hole;
    t_dir                r_nb;
    logic [CELL_W-1:0]   r_ncell, r_trc;
    logic [LEN_W-1:0]    r_stored_len, r_len, r_tidx;
    t_status             r_status;
    logic [CELL_W-1:0]   r_ocell;
    logic                r_olast;
    logic                r_ovalid;
    t_rsp                r_odata;

    // divider and rasterizer registers
    logic [1:0]          r_div_idx;
    logic [QW-1:0]       r_left, r_top, r_right, r_bot, r_fc, r_fr;

    // request cells
    logic [CELL_W-1:0]   w_start, w_goal;
    assign w_start = {r_req.start_row, r_req.start_col};
    assign w_goal  = {r_req.goal_row,  r_req.goal_col};

    logic w_acc, w_out_free, w_sweep_end;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_out_free  = !r_ovalid || o_rsp.ready;
    assign w_sweep_end = (r_sweep == CELL_W'(NCELLS - 1));

    // rectangle edges in pixels
    logic [QW-1:0] w_lo_x, w_lo_y, w_hi_x, w_hi_y, w_dividend;
    logic          w_neg;
    assign w_lo_x = {1'b0, r_req.wall_center_x} - QW'(r_req.wall_width[PX_W-1:1]);
    assign w_lo_y = {1'b0, r_req.wall_center_y} - QW'(r_req.wall_height[PX_W-1:1]);
    assign w_hi_x = {1'b0, r_req.wall_center_x} + QW'(r_req.wall_width[PX_W-1:1]);
    assign w_hi_y = {1'b0, r_req.wall_center_y} + QW'(r_req.wall_height[PX_W-1:1]);

    always_comb begin
        case (r_div_idx)
            2'd0:    w_dividend = w_lo_x;
            2'd1:    w_dividend = w_lo_y;
            2'd2:    w_dividend = w_hi_x;
            default: w_dividend = w_hi_y;
        endcase
    end
    assign w_neg = (r_div_idx == 2'd0) ? (r_req.wall_center_x < QW'(r_req.wall_width[PX_W-1:1]))
                 : (r_div_idx == 2'd1) ? (r_req.wall_center_y < QW'(r_req.wall_height[PX_W-1:1]))
                 : 1'b0;

    // one edge per cycle divided by the cell size through a reciprocal multiply
    logic [PW-1:0] w_div_prod;
    logic [QW-1:0] w_quo_n, w_quo_clx, w_quo_cly;
    assign w_div_prod = PW'(w_dividend) * PW'(DIV_M);
    assign w_quo_n    = w_div_prod[PW-1:DIV_S];
    assign w_quo_clx  = (w_quo_n > QW'(GRID_W - 1)) ? QW'(GRID_W - 1) : w_quo_n;
    assign w_quo_cly  = (w_quo_n > QW'(GRID_H - 1)) ? QW'(GRID_H - 1) : w_quo_n;

    logic w_fill_skip, w_fill_rend, w_fill_cend;
    assign w_fill_skip = (r_left > r_right) || (r_top > r_bot);
    assign w_fill_rend = (r_fr == r_bot);
    assign w_fill_cend = (r_fc == r_right);

    // heap index arithmetic
    logic [LW-1:0]  w_l, w_r;
    logic [HIW-1:0] w_par_idx;
    logic           w_l_ok, w_r_ok, w_heap_full;
    assign w_l         = {1'b0, r_hole, 1'b1};
    assign w_r         = w_l + 1'b1;
    assign w_l_ok      = (w_l < LW'(r_cnt));
    assign w_r_ok      = (w_r < LW'(r_cnt));
    assign w_par_idx   = (r_hole - 1'b1) >> 1;
    assign w_heap_full = (r_cnt >= CNTW'(OPEN_DEPTH));

    // sift-down child choice
    logic      w_pick_l, w_pick_r;
    t_heap_ent w_best;
    always_comb begin
        w_pick_l = heap_before(r_cl, r_mov);
        w_best   = w_pick_l ? r_cl : r_mov;
        w_pick_r = w_r_ok && heap_before(r_heap_q, w_best);
        if (w_pick_r) begin
            w_best = r_heap_q;
        end
    end

    // neighbor of the current cell
    logic [COL_W-1:0]  w_ccol;
    logic [ROW_W-1:0]  w_crow;
    logic [CELL_W-1:0] w_ncell;
    logic              w_nb_ok;
    assign w_ccol = r_cur.loc[COL_W-1:0];
    assign w_crow = r_cur.loc[CELL_W-1:COL_W];
    always_comb begin
        case (r_nb)
            DIR_E: begin
                w_nb_ok = (w_ccol != COL_W'(GRID_W - 1));
                w_ncell = {w_crow, w_ccol + 1'b1};
            end
            DIR_S: begin
                w_nb_ok = (w_crow != ROW_W'(GRID_H - 1));
                w_ncell = {w_crow + 1'b1, w_ccol};
            end
            DIR_W: begin
                w_nb_ok = (w_ccol != '0);
                w_ncell = {w_crow, w_ccol - 1'b1};
            end
            default: begin
                w_nb_ok = (w_crow != '0);
                w_ncell = {w_crow - 1'b1, w_ccol};
            end
        endcase
    end

    logic w_nb_last;
    assign w_nb_last = (r_nb == DIR_N);

    logic w_rd_range;
    assign w_rd_range = (LEN_W'(r_req.step_index) >= r_stored_len);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_INIT:   if (w_sweep_end) n_state = S_IDLE;
            S_IDLE: begin
                if (w_acc) begin
                    case (i_req.data.opcode)
                        OP_CLEAR:  n_state = S_WCLR;
                        OP_WALL:   n_state = S_DIV;
                        OP_SEARCH: n_state = S_SGOAL;
                        default:   n_state = S_RD0;
                    endcase
                end
            end
            S_WCLR:   if (w_sweep_end) n_state = S_DONE;
            S_DIV:    if (r_div_idx == 2'd3) n_state = S_FILL;
            S_FILL:   if (w_fill_skip || (w_fill_rend && w_fill_cend)) n_state = S_DONE;
            S_SGOAL:  n_state = S_SCHK;
            S_SCHK:   n_state = r_wall_q ? S_DONE : S_CCLR;
            S_CCLR:   if (w_sweep_end) n_state = S_PUSH;
            S_PUSH:   n_state = !w_heap_full ? S_SU_A : (w_nb_last ? S_POP0 : S_NB0);
            S_SU_A: begin
                if (r_hole != '0) n_state = S_SU_B;
                else              n_state = w_nb_last ? S_POP0 : S_NB0;
            end
            S_SU_B: begin
                if (heap_before(r_mov, r_heap_q)) n_state = S_SU_A;
                else                              n_state = w_nb_last ? S_POP0 : S_NB0;
            end
            S_POP0:   n_state = (r_cnt == '0) ? S_DONE : S_POP1;
            S_POP1:   n_state = (r_cnt == CNTW'(1)) ? S_CLOSE0 : S_POP2;
            S_POP2:   n_state = S_SD_A;
            S_SD_A:   n_state = w_l_ok ? S_SD_B : S_CLOSE0;
            S_SD_B:   n_state = S_SD_C;
            S_SD_C:   n_state = (w_pick_l || w_pick_r) ? S_SD_A : S_CLOSE0;
            S_CLOSE0: n_state = S_CLOSE1;
            S_CLOSE1: begin
                if (r_closed_q)               n_state = S_POP0;
                else if (r_cur.loc == w_goal) n_state = S_TR_A;
                else                          n_state = S_NB0;
            end
            S_NB0: begin
                if (w_nb_ok)        n_state = S_NB1;
                else if (w_nb_last) n_state = S_POP0;
            end
            S_NB1: begin
                if (!(r_wall_q || r_closed_q)) n_state = S_PUSH;
                else if (w_nb_last)            n_state = S_POP0;
                else                           n_state = S_NB0;
            end
            S_TR_A:   n_state = (r_trc == w_start) ? S_TW_A : S_TR_B;
            S_TR_B:   n_state = S_TR_A;
            S_TW_A:   n_state = (r_tidx == LEN_W'(1)) ? S_DONE : S_TW_B;
            S_TW_B:   n_state = S_TW_A;
            S_RD0:    n_state = w_rd_range ? S_DONE : S_RD1;
            S_RD1:    n_state = S_DONE;
            S_DONE:   if (w_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // memory strobes and handshake outputs
    always_comb begin
        w_wall_we      = 1'b0;
        w_wall_wd      = 1'b0;
        w_wall_waddr   = r_sweep;
        w_wall_raddr   = w_ncell;
        w_closed_we    = 1'b0;
        w_closed_wd    = 1'b0;
        w_closed_waddr = r_sweep;
        w_closed_raddr = w_ncell;
        w_par_we       = 1'b0;
        w_par_raddr    = r_trc;
        w_path_we      = 1'b0;
        w_path_waddr   = IDX_W'(r_tidx - 1'b1);
        w_path_raddr   = r_req.step_index;
        w_heap_we      = 1'b0;
        w_heap_waddr   = r_hole;
        w_heap_wd      = r_mov;
        w_heap_raddr   = '0;
        case (r_state)
            S_INIT, S_WCLR: begin
                w_wall_we = 1'b1;
            end
            S_FILL: begin
                w_wall_we    = !w_fill_skip;
                w_wall_wd    = 1'b1;
                w_wall_waddr = {r_fr[ROW_W-1:0], r_fc[COL_W-1:0]};
            end
            S_SGOAL: begin
                w_wall_raddr = w_goal;
            end
            S_CCLR: begin
                w_closed_we = 1'b1;
            end
            S_SU_A: begin
                w_heap_we    = (r_hole == '0);
                w_heap_raddr = w_par_idx;
            end
            S_SU_B: begin
                w_heap_we = 1'b1;
                if (heap_before(r_mov, r_heap_q)) begin
                    w_heap_wd = r_heap_q;
                end
            end
            S_POP1: begin
                w_heap_raddr = HIW'(r_cnt - 1'b1);
            end
            S_SD_A: begin
                w_heap_we    = !w_l_ok;
                w_heap_raddr = w_l[HIW-1:0];
            end
            S_SD_B: begin
                w_heap_raddr = w_r[HIW-1:0];
            end
            S_SD_C: begin
                w_heap_we = 1'b1;
                w_heap_wd = w_best;
            end
            S_CLOSE0: begin
                w_closed_raddr = r_cur.loc;
            end
            S_CLOSE1: begin
                w_closed_we    = !r_closed_q;
                w_closed_wd    = 1'b1;
                w_closed_waddr = r_cur.loc;
                w_par_we       = !r_closed_q;
            end
            S_TW_A: begin
                w_path_we = 1'b1;
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data  = r_odata;

    // memories: one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (w_wall_we) r_wall_mem[w_wall_waddr] <= w_wall_wd;
        r_wall_q <= r_wall_mem[w_wall_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_closed_we) r_closed_mem[w_closed_waddr] <= w_closed_wd;
        r_closed_q <= r_closed_mem[w_closed_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_par_we) r_par_mem[r_cur.loc] <= r_cur.dir;
        r_par_q <= r_par_mem[w_par_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_path_we) r_path_mem[w_path_waddr] <= r_trc;
        r_path_q <= r_path_mem[w_path_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_heap_we) r_heap_mem[w_heap_waddr] <= w_heap_wd;
        r_heap_q <= r_heap_mem[w_heap_raddr];
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_sweep      <= '0;
            r_stored_len <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_INIT || r_state == S_WCLR || r_state == S_CCLR) begin
                r_sweep <= r_sweep + 1'b1;
            end
            if (r_state == S_IDLE && w_acc && i_req.data.opcode == OP_SEARCH) begin
                r_stored_len <= '0;
            end
            if (r_state == S_TR_A && r_trc == w_start) begin
                r_stored_len <= r_len;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_ovalid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_acc) begin
                    r_req     <= i_req.data;
                    r_status  <= ST_OK;
                    r_ocell   <= '0;
                    r_olast   <= 1'b0;
                    r_div_idx <= '0;
                end
            end
            S_DIV: begin
                case (r_div_idx)
                    2'd0:    r_left  <= w_neg ? '0 : w_quo_n;
                    2'd1:    r_top   <= w_neg ? '0 : w_quo_n;
                    2'd2:    r_right <= w_quo_clx;
                    default: r_bot   <= w_quo_cly;
                endcase
                r_div_idx <= r_div_idx + 1'b1;
                r_fc      <= r_left;
                r_fr      <= r_top;
            end
            S_FILL: begin
                // walk rows inside a column, then step the column
                if (w_fill_rend) begin
                    r_fr <= r_top;
                    r_fc <= r_fc + 1'b1;
                end else begin
                    r_fr <= r_fr + 1'b1;
                end
            end
            S_SCHK: begin
                if (r_wall_q) r_status <= ST_NOPATH;
            end
            S_CCLR: begin
                r_mov <= '{f: manhattan(w_start, r_req.goal_col, r_req.goal_row),
                           seq: '0, loc: w_start, dir: DIR_E};
                r_seq <= SEQ_W'(1);
                r_cnt <= '0;
                r_nb  <= DIR_N;
            end
            S_PUSH: begin
                if (!w_heap_full) begin
                    r_hole <= r_cnt[HIW-1:0];
                    r_cnt  <= r_cnt + 1'b1;
                end else if (!w_nb_last) begin
                    r_nb <= t_dir'(r_nb + 1'b1);
                end
            end
            S_SU_A: begin
                if (r_hole == '0 && !w_nb_last) r_nb <= t_dir'(r_nb + 1'b1);
            end
            S_SU_B: begin
                if (heap_before(r_mov, r_heap_q)) begin
                    r_hole <= w_par_idx;
                end else if (!w_nb_last) begin
                    r_nb <= t_dir'(r_nb + 1'b1);
                end
            end
            S_POP0: begin
                if (r_cnt == '0) r_status <= ST_NOPATH;
            end
            S_POP1: begin
                r_cur  <= r_heap_q;
                r_cnt  <= r_cnt - 1'b1;
                r_hole <= '0;
            end
            S_POP2: begin
                r_mov <= r_heap_q;
            end
            S_SD_B: begin
                r_cl <= r_heap_q;
            end
            S_SD_C: begin
                if (w_pick_r)      r_hole <= w_r[HIW-1:0];
                else if (w_pick_l) r_hole <= w_l[HIW-1:0];
            end
            S_CLOSE0: begin
                r_cur_g <= r_cur.f - manhattan(r_cur.loc, r_req.goal_col, r_req.goal_row);
            end
            S_CLOSE1: begin
                r_nb  <= DIR_E;
                r_trc <= w_goal;
                r_len <= LEN_W'(1);
            end
            S_NB0: begin
                r_ncell <= w_ncell;
                if (!w_nb_ok && !w_nb_last) r_nb <= t_dir'(r_nb + 1'b1);
            end
            S_NB1: begin
                if (!(r_wall_q || r_closed_q)) begin
                    r_mov <= '{f: r_cur_g + 1'b1
                                  + manhattan(r_ncell, r_req.goal_col, r_req.goal_row),
                               seq: r_seq, loc: r_ncell, dir: r_nb};
                    r_seq <= r_seq + 1'b1;
                end else if (!w_nb_last) begin
                    r_nb <= t_dir'(r_nb + 1'b1);
                end
            end
            S_TR_A: begin
                if (r_trc == w_start) begin
                    r_tidx <= r_len;
                    r_trc  <= w_goal;
                end
            end
            S_TR_B: begin
                r_trc <= step_back(r_trc, r_par_q);
                r_len <= r_len + 1'b1;
            end
            S_TW_B: begin
                r_trc  <= step_back(r_trc, r_par_q);
                r_tidx <= r_tidx - 1'b1;
            end
            S_RD0: begin
                if (w_rd_range) r_status <= ST_RANGE;
            end
            S_RD1: begin
                r_ocell <= r_path_q;
                r_olast <= (LEN_W'(r_req.step_index) + 1'b1 == r_stored_len);
            end
            S_DONE: begin
                if (w_out_free) begin
                    r_odata <= '{status: r_status, path_length: r_stored_len,
                                 cell_col: r_ocell[COL_W-1:0],
                                 cell_row: r_ocell[CELL_W-1:COL_W],
                                 is_last_step: r_olast};
                end
            end
            default: ;
        endcase
    end

endmodule

@@ dv/grid_astar_path_search_unit_test.sv @@
// ----------------------------------------------------------------------------
// grid_astar_path_search_unit_test - grid path search unit testbench
// Drives clear, add-wall, search and path-read requests through the request
// channel with random gaps and response stalls. A behavioral route planner
// kept in step with the unit predicts every response, which is checked field
// by field in order.
// ----------------------------------------------------------------------------
module grid_astar_path_search_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gaps_pkg::*;

    localparam int N_RANDOM = 1520;

    // one open-list node of the planner
    typedef struct {
        int f;
        int seq;
        int g;
        int loc;
        int dir;
    } node_t;

    logic i_clk;
    logic i_rst_n;

    gaps_chan_if #(.T(t_req)) req_ch ();
    gaps_chan_if #(.T(t_rsp)) rsp_ch ();

    grid_astar_path_search_unit uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // planner state
    bit    wall_m   [NCELLS];
    bit    closed_m [NCELLS];
    int    from_dir [NCELLS];
    int    route    [NCELLS];
    int    route_len;
    node_t open_list [OPEN_DEPTH_DEF];
    int    open_cnt;

    t_rsp  pending_rsp [$];
    int    mismatches;
    int    rsp_seen;
    int    n_found;
    int    n_failed;
    int    n_reads;
    int    rx_hold;
    bit    no_idle;

    // clock
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    function automatic int step_dx(input int d);
        return (d == DIR_E) ? 1 : (d == DIR_W) ? -1 : 0;
    endfunction

    function automatic int step_dy(input int d);
        return (d == DIR_S) ? 1 : (d == DIR_N) ? -1 : 0;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 15);
        if (no_idle || r < 8) return 0;
        if (r < 14) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // lower f first, on equal f the later push
    function automatic bit pops_first(input node_t a, input node_t b);
        if (a.f != b.f) return a.f < b.f;
        return a.seq > b.seq;
    endfunction

    function automatic void open_push(input node_t e);
        int    i;
        int    p;
        node_t t;
        if (open_cnt >= OPEN_DEPTH_DEF) return;
        i = open_cnt;
        open_cnt++;
        open_list[i] = e;
        while (i > 0) begin
            p = (i - 1) / 2;
            if (!pops_first(open_list[i], open_list[p])) break;
            t = open_list[i];
            open_list[i] = open_list[p];
            open_list[p] = t;
            i = p;
        end
    endfunction

    function automatic node_t open_pop();
        node_t top;
        node_t t;
        int    i;
        int    l;
        int    m;
        top = open_list[0];
        open_cnt--;
        open_list[0] = open_list[open_cnt];
        i = 0;
        forever begin
            l = 2 * i + 1;
            m = i;
            if (l < open_cnt && pops_first(open_list[l], open_list[m])) m = l;
            if (l + 1 < open_cnt && pops_first(open_list[l + 1], open_list[m])) m = l + 1;
            if (m == i) break;
            t = open_list[i];
            open_list[i] = open_list[m];
            open_list[m] = t;
            i = m;
        end
        return top;
    endfunction

    function automatic int cell_back(input int c);
        int d;
        d = from_dir[c];
        return (c / GRID_W - step_dy(d)) * GRID_W + (c % GRID_W - step_dx(d));
    endfunction

    function automatic void mark_rect(input int x, input int y, input int w, input int h);
        int lox;
        int loy;
        int left;
        int top;
        int right;
        int bottom;
        lox    = x - w / 2;
        loy    = y - h / 2;
        left   = (lox < 0) ? 0 : lox / CELL_PX;
        top    = (loy < 0) ? 0 : loy / CELL_PX;
        right  = (x + w / 2) / CELL_PX;
        bottom = (y + h / 2) / CELL_PX;
        if (right > GRID_W - 1) right = GRID_W - 1;
        if (bottom > GRID_H - 1) bottom = GRID_H - 1;
        for (int c = left; c <= right; c++)
            for (int r = top; r <= bottom; r++)
                wall_m[r * GRID_W + c] = 1'b1;
    endfunction

    // A* from start to goal; fills the route store on success
    function automatic bit plan_route(input int sc, input int sr, input int gc, input int gr);
        int    start;
        int    goal;
        int    seq;
        int    len;
        int    c;
        int    nc;
        int    nr;
        int    n;
        node_t cur;
        node_t nx;
        route_len = 0;
        goal  = gr * GRID_W + gc;
        start = sr * GRID_W + sc;
        if (wall_m[goal]) return 1'b0;
        closed_m = '{default: 1'b0};
        open_cnt = 0;
        seq = 0;
        nx = '{f: ((sc > gc) ? sc - gc : gc - sc) + ((sr > gr) ? sr - gr : gr - sr),
               seq: seq, g: 0, loc: start, dir: DIR_E};
        seq++;
        open_push(nx);
        while (open_cnt > 0) begin
            cur = open_pop();
            if (closed_m[cur.loc]) continue;
            closed_m[cur.loc] = 1'b1;
            from_dir[cur.loc] = cur.dir;
            if (cur.loc == goal) begin
                len = 1;
                for (c = goal; c != start; len++) c = cell_back(c);
                route_len = len;
                c = goal;
                for (int i = len - 1; i >= 0; i--) begin
                    route[i] = c;
                    if (i > 0) c = cell_back(c);
                end
                return 1'b1;
            end
            for (int d = 0; d < 4; d++) begin
                nc = cur.loc % GRID_W + step_dx(d);
                nr = cur.loc / GRID_W + step_dy(d);
                if (nc < 0 || nc >= GRID_W || nr < 0 || nr >= GRID_H) continue;
                n = nr * GRID_W + nc;
                if (wall_m[n] || closed_m[n]) continue;
                nx.g   = cur.g + 1;
                nx.f   = nx.g + ((nc > gc) ? nc - gc : gc - nc) + ((nr > gr) ? nr - gr : gr - nr);
                nx.seq = seq;
                nx.loc = n;
                nx.dir = d;
                seq++;
                open_push(nx);
            end
        end
        return 1'b0;
    endfunction

    // expected response of one request, updating the planner state
    function automatic t_rsp predict_rsp(input t_req q);
        t_rsp r;
        int   idx;
        r = '0;
        r.status = ST_OK;
        case (q.opcode)
            OP_CLEAR: wall_m = '{default: 1'b0};
            OP_WALL:  mark_rect(int'(q.wall_center_x), int'(q.wall_center_y),
                                int'(q.wall_width), int'(q.wall_height));
            OP_SEARCH: begin
                if (plan_route(int'(q.start_col), int'(q.start_row),
                               int'(q.goal_col), int'(q.goal_row))) begin
                    n_found++;
                end else begin
                    r.status = ST_NOPATH;
                    n_failed++;
                end
            end
            default: begin
                idx = int'(q.step_index);
                n_reads++;
                if (idx >= route_len) begin
                    r.status = ST_RANGE;
                end else begin
                    r.cell_col     = COL_W'(route[idx] % GRID_W);
                    r.cell_row     = ROW_W'(route[idx] / GRID_W);
                    r.is_last_step = (idx + 1 == route_len);
                end
            end
        endcase
        r.path_length = LEN_W'((route_len > 4095) ? 4095 : route_len);
        return r;
    endfunction

    // send one request; valid stays high on return
    task automatic send_req(input t_req q);
        int   gap;
        t_rsp exp_r;
        gap = gap_len();
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.data  <= q;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        exp_r = predict_rsp(q);
        pending_rsp.insert(pending_rsp.size(), exp_r);
    endtask

    function automatic t_req noise_req();
        t_req        q;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        q = t_req'(raw[$bits(t_req)-1:0]);
        return q;
    endfunction

    task automatic send_op(input t_op op, input int a, input int b, input int c, input int d);
        t_req q;
        q = noise_req();
        q.opcode = op;
        case (op)
            OP_WALL: begin
                q.wall_center_x = PX_W'(a);
                q.wall_center_y = PX_W'(b);
                q.wall_width    = PX_W'(c);
                q.wall_height   = PX_W'(d);
            end
            OP_SEARCH: begin
                q.start_col = COL_W'(a);
                q.start_row = ROW_W'(b);
                q.goal_col  = COL_W'(c);
                q.goal_row  = ROW_W'(d);
            end
            OP_READ: q.step_index = IDX_W'(a);
            default: ;
        endcase
        send_req(q);
    endtask

    // wall on a single cell
    task automatic wall_cell(input int col, input int row);
        send_op(OP_WALL, col * CELL_PX + 15, row * CELL_PX + 15, 0, 0);
    endtask

    // hold the sender until every expected response has come
    task automatic drain_rsp();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // response checker and ready stalls
    always @(posedge i_clk) begin
        t_rsp exp_r;
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_seen++;
                if (pending_rsp.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected response %p", rsp_ch.data);
                end else begin
                    exp_r = pending_rsp.pop_front();
                    if (rsp_ch.data.status !== exp_r.status
                            || rsp_ch.data.path_length !== exp_r.path_length
                            || rsp_ch.data.cell_col !== exp_r.cell_col
                            || rsp_ch.data.cell_row !== exp_r.cell_row
                            || rsp_ch.data.is_last_step !== exp_r.is_last_step) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("response %0d mismatch: expected %p, got %p",
                                     rsp_seen, exp_r, rsp_ch.data);
                    end
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= 1'b1;
                if ($urandom_range(0, 5) == 0) rx_hold = gap_len();
            end
        end
    end

    // corner cases: trivial and long routes, range reads, clamped walls
    task automatic test_routes();
        send_op(OP_SEARCH, 0, 0, 0, 0);
        send_op(OP_READ, 0, 0, 0, 0);
        send_op(OP_READ, 1, 0, 0, 0);
        send_op(OP_SEARCH, 0, 0, 63, 31);
        send_op(OP_READ, 93, 0, 0, 0);
        send_op(OP_READ, 94, 0, 0, 0);
        send_op(OP_READ, 2047, 0, 0, 0);
        send_op(OP_WALL, 4095, 4095, 4095, 4095);
        send_op(OP_WALL, 0, 0, 0, 0);
        send_op(OP_SEARCH, 0, 0, 5, 0);
        send_op(OP_READ, 3, 0, 0, 0);
        send_op(OP_WALL, 1000, 200, 150, 61);
        send_op(OP_SEARCH, 63, 31, 30, 2);
        drain_rsp();
    endtask

    // no route: blocked goal, boxed-in start, grid full of walls
    task automatic test_no_route();
        wall_cell(10, 10);
        send_op(OP_SEARCH, 12, 10, 10, 10);
        wall_cell(21, 20);
        wall_cell(19, 20);
        wall_cell(20, 19);
        wall_cell(20, 21);
        send_op(OP_SEARCH, 20, 20, 40, 5);
        send_op(OP_READ, 0, 0, 0, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0);
        send_op(OP_SEARCH, 20, 20, 21, 20);
        send_op(OP_WALL, 2000, 2000, 4095, 4095);
        send_op(OP_SEARCH, 0, 0, 1, 0);
        send_op(OP_CLEAR, 0, 0, 0, 0);
        drain_rsp();
    endtask

    // random mix, mostly short searches and reads of the stored route
    task automatic test_random_mix();
        t_req q;
        int   k;
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n % 100 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (n % 400 == 399) drain_rsp();
            q = noise_req();
            k = $urandom_range(0, 99);
            if (k < 4) begin
                q.opcode = OP_CLEAR;
            end else if (k < 32) begin
                q.opcode = OP_WALL;
                if ($urandom_range(0, 1) == 0) begin
                    q.wall_center_x = PX_W'($urandom_range(0, GRID_W * CELL_PX - 1));
                    q.wall_center_y = PX_W'($urandom_range(0, GRID_H * CELL_PX - 1));
                end
                if ($urandom_range(0, 15) != 0) begin
                    q.wall_width  = PX_W'($urandom_range(0, 120));
                    q.wall_height = PX_W'($urandom_range(0, 120));
                end
            end else if (k < 48) begin
                q.opcode = OP_SEARCH;
                if ($urandom_range(0, 9) != 0) begin
                    q.goal_col = COL_W'(int'(q.start_col) + int'($urandom_range(0, 24)) - 12);
                    q.goal_row = ROW_W'(int'(q.start_row) + int'($urandom_range(0, 12)) - 6);
                end
            end else begin
                q.opcode = OP_READ;
                if (route_len > 0 && $urandom_range(0, 4) != 0)
                    q.step_index = IDX_W'($urandom_range(0, route_len));
            end
            send_req(q);
        end
    endtask

    // stimulus
    initial begin
        i_rst_n      = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.data  = '0;
        rsp_ch.ready = 1'b0;
        mismatches   = 0;
        rsp_seen     = 0;
        n_found      = 0;
        n_failed     = 0;
        n_reads      = 0;
        rx_hold      = 0;
        no_idle      = 1'b0;
        route_len    = 0;
        open_cnt     = 0;
        wall_m       = '{default: 1'b0};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_routes();
        test_no_route();
        test_random_mix();

        drain_rsp();
        repeat (50) @(posedge i_clk);
        $display("Covered %0d responses: %0d routes found, %0d searches without a route,",
                 rsp_seen, n_found, n_failed);
        $display("%0d route reads, %0d mismatches", n_reads, mismatches);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // watchdog
    initial begin
        #400_000_000;
        $display("Timeout: %0d responses still expected", pending_rsp.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
